/* rtl/salc_pkg.sv */
// ----------------------------------------------------------------------------
// salc_pkg
// shared widths, codes and types of the set-associative cache model
// ----------------------------------------------------------------------------
package salc_pkg;

	// default sizes handed to the top level
	localparam int SET_COUNT_DEF   = 64;
	localparam int WAY_COUNT_DEF   = 8;
	localparam int TOTAL_WIDTH_DEF = 32;

	// fixed field widths
	localparam int ADDR_W       = 64;
	localparam int OP_W         = 2;
	localparam int SET_BITS_W   = 3;
	localparam int BLOCK_BITS_W = 6;
	localparam int WAYS_W       = 4;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 6;
	localparam int SHIFT_W      = 7;
	localparam int OUT_TOTAL_W  = 32;

	// stream payload widths, padded to whole bytes
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 104;

	// reset values of the configuration registers
	localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
	localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;
	localparam logic [WAYS_W-1:0]       WAYS_USED_RST  = 4'd1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_BITS   = 2'd0,
		CFG_BLOCK_BITS = 2'd1,
		CFG_WAYS_USED  = 2'd2
	} cfg_idx_t;

	// access kinds, the unused code behaves as a load
	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_STORE  = 2'd1,
		OP_MODIFY = 2'd2
	} op_t;

	// outcome of one set lookup
	typedef struct packed {
		logic hit;
		logic evicted;
	} lookup_stat_t;

endpackage

/* rtl/set_assoc_lru_cache_model.sv */
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// tag-only set-associative cache with true lru replacement and running totals
// ----------------------------------------------------------------------------
// Each transfer on the slave stream is one access (load, store or modify) to a
// 64-bit byte address; each access yields exactly one result transfer on the
// master stream with hit, miss and eviction flags and the saturating totals.
// All ways of a set live in one row of a single synchronous memory: the set
// row is read when the access is taken, and in the compare stage the tags are
// compared, the victim is picked, the ages are updated and the row is written
// back once the result register can take the result. A new access is taken
// only after the previous one has left the compare stage. A modify counts its
// second access as an extra hit in the same pass. After reset the block runs
// a clearing pass over every row of the memory before it takes the first
// access; configuration writes are taken at any time but are meant to be
// issued only while the block is idle.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model #(
	parameter int SET_COUNT   = salc_pkg::SET_COUNT_DEF,
	parameter int WAY_COUNT   = salc_pkg::WAY_COUNT_DEF,
	parameter int TOTAL_WIDTH = salc_pkg::TOTAL_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data,
	// access stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [salc_pkg::S_TDATA_W-1:0]   s_tdata,   // op[1:0], address[65:2]
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// was_hit[0], was_miss[1], was_eviction[2], second_hit[3],
	// hit_total[35:4], miss_total[67:36], eviction_total[99:68]
	output logic [salc_pkg::M_TDATA_W-1:0]   m_tdata
);
	import salc_pkg::*;

	localparam int IDX_W       = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int SET_IDX_MAX = $clog2(SET_COUNT + 1) - 1;   // floor log2
	localparam int REC_W       = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
	localparam int WAY_BITS    = 1 + REC_W + ADDR_W;
	localparam int ROW_W       = WAY_COUNT * WAY_BITS;
	localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

	// configuration registers
	logic [SET_BITS_W-1:0]   set_bits_q;
	logic [BLOCK_BITS_W-1:0] block_bits_q;
	logic [WAYS_W-1:0]       ways_used_q;

	// address split
	logic [OP_W-1:0]         in_op;
	logic [ADDR_W-1:0]       in_addr;
	logic [SET_BITS_W-1:0]   set_eff;
	logic [SHIFT_W-1:0]      tag_shift;
	logic [ADDR_W-1:0]       addr_sh;
	logic [IDX_W:0]          idx_mask;
	logic [IDX_W-1:0]        in_idx;
	logic [ADDR_W-1:0]       in_tag;

	// clearing pass
	logic                    clear_busy_q;
	logic [IDX_W-1:0]        clr_idx_q;

	// set memory
	logic [ROW_W-1:0]        set_mem [SET_COUNT];
	logic [ROW_W-1:0]        rd_row_q;
	logic                    rd_en;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_idx;
	logic [ROW_W-1:0]        wr_row;
	logic [ROW_W-1:0]        new_row;

	// compare stage
	logic                    valid_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic [ADDR_W-1:0]       tag_s1;
	logic                    twice_s1;
	logic                    s_fire;
	logic                    s1_fire;

	// row fields in and out of the lookup
	logic                    row_valid [WAY_COUNT];
	logic [ADDR_W-1:0]       row_tag   [WAY_COUNT];
	logic [REC_W-1:0]        row_rec   [WAY_COUNT];
	logic                    new_valid [WAY_COUNT];
	logic [ADDR_W-1:0]       new_tag   [WAY_COUNT];
	logic [REC_W-1:0]        new_rec   [WAY_COUNT];
	lookup_stat_t            lk_stat;

	// totals
	logic [TOTAL_WIDTH-1:0]  hits_q;
	logic [TOTAL_WIDTH-1:0]  misses_q;
	logic [TOTAL_WIDTH-1:0]  evicts_q;
	logic [1:0]              hit_inc;
	logic                    miss_inc;
	logic                    evict_inc;
	logic [TOTAL_WIDTH:0]    hits_sum;
	logic [TOTAL_WIDTH:0]    misses_sum;
	logic [TOTAL_WIDTH:0]    evicts_sum;
	logic [TOTAL_WIDTH-1:0]  hits_nxt;
	logic [TOTAL_WIDTH-1:0]  misses_nxt;
	logic [TOTAL_WIDTH-1:0]  evicts_nxt;
	logic [63:0]             hits_ext;
	logic [63:0]             misses_ext;
	logic [63:0]             evicts_ext;

	// result register
	logic                    m_valid_q;
	logic                    res_hit_q;
	logic                    res_miss_q;
	logic                    res_evict_q;
	logic                    res_twice_q;
	logic [OUT_TOTAL_W-1:0]  res_hits_q;
	logic [OUT_TOTAL_W-1:0]  res_misses_q;
	logic [OUT_TOTAL_W-1:0]  res_evicts_q;

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= SET_BITS_RST;
			block_bits_q <= BLOCK_BITS_RST;
			ways_used_q  <= WAYS_USED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SET_BITS:   set_bits_q   <= cfg_data[SET_BITS_W-1:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_data[BLOCK_BITS_W-1:0];
				CFG_WAYS_USED:  ways_used_q  <= cfg_data[WAYS_W-1:0];
				default: ;  // writes past the register list are dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// handshake: one access in flight, memory busy while clearing
	// ------------------------------------------------------------------
	assign s_tready = !clear_busy_q && !valid_s1;
	assign s_fire   = s_tvalid && s_tready;
	assign s1_fire  = valid_s1 && (!m_valid_q || m_tready);

	// ------------------------------------------------------------------
	// set index and tag from the incoming address
	// ------------------------------------------------------------------
	assign in_op   = s_tdata[OP_W-1:0];
	assign in_addr = s_tdata[OP_W +: ADDR_W];

	always_comb begin
		// set bits clamp to what the memory depth can index
		if (32'(set_bits_q) > SET_IDX_MAX) begin
			set_eff = SET_BITS_W'(SET_IDX_MAX);
		end else begin
			set_eff = set_bits_q;
		end
		tag_shift = SHIFT_W'(set_eff) + SHIFT_W'(block_bits_q);
		addr_sh   = in_addr >> block_bits_q;
		idx_mask  = ((IDX_W + 1)'(1) << set_eff) - (IDX_W + 1)'(1);
		in_idx    = addr_sh[IDX_W-1:0] & idx_mask[IDX_W-1:0];
		// a shift of 64 or more leaves a zero tag
		in_tag    = in_addr >> tag_shift;
	end

	// ------------------------------------------------------------------
	// clearing pass after reset
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_busy_q <= 1'b1;
			clr_idx_q    <= '0;
		end else if (clear_busy_q) begin
			if (clr_idx_q == IDX_W'(SET_COUNT - 1)) begin
				clear_busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// set memory: read on accept, write back after compare
	// ------------------------------------------------------------------
	assign rd_en  = s_fire;
	assign wr_en  = clear_busy_q || s1_fire;
	assign wr_idx = clear_busy_q ? clr_idx_q : idx_s1;
	assign wr_row = clear_busy_q ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			set_mem[wr_idx] <= wr_row;
		end
		if (rd_en) begin
			rd_row_q <= set_mem[in_idx];
		end
	end

	// ------------------------------------------------------------------
	// compare stage
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			idx_s1   <= in_idx;
			tag_s1   <= in_tag;
			twice_s1 <= (in_op == OP_MODIFY);
		end
	end

	// row layout per way: valid, age, tag from the low bit up
	for (genvar w = 0; w < WAY_COUNT; w++) begin : g_row
		assign row_valid[w] = rd_row_q[w*WAY_BITS];
		assign row_rec[w]   = rd_row_q[w*WAY_BITS + 1 +: REC_W];
		assign row_tag[w]   = rd_row_q[w*WAY_BITS + 1 + REC_W +: ADDR_W];
		assign new_row[w*WAY_BITS]                      = new_valid[w];
		assign new_row[w*WAY_BITS + 1 +: REC_W]         = new_rec[w];
		assign new_row[w*WAY_BITS + 1 + REC_W +: ADDR_W] = new_tag[w];
	end

	salc_lookup #(
		.WAY_COUNT (WAY_COUNT),
		.REC_W     (REC_W)
	) u_lookup (
		.ways_used (ways_used_q),
		.tag       (tag_s1),
		.row_valid (row_valid),
		.row_tag   (row_tag),
		.row_rec   (row_rec),
		.new_valid (new_valid),
		.new_tag   (new_tag),
		.new_rec   (new_rec),
		.stat      (lk_stat)
	);

	// ------------------------------------------------------------------
	// saturating totals, a modify adds its second hit here
	// ------------------------------------------------------------------
	always_comb begin
		hit_inc    = 2'(lk_stat.hit) + 2'(twice_s1);
		miss_inc   = !lk_stat.hit;
		evict_inc  = lk_stat.evicted;
		hits_sum   = {1'b0, hits_q} + (TOTAL_WIDTH + 1)'(hit_inc);
		misses_sum = {1'b0, misses_q} + (TOTAL_WIDTH + 1)'(miss_inc);
		evicts_sum = {1'b0, evicts_q} + (TOTAL_WIDTH + 1)'(evict_inc);
		hits_nxt   = (hits_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX
			: hits_sum[TOTAL_WIDTH-1:0];
		misses_nxt = (misses_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX
			: misses_sum[TOTAL_WIDTH-1:0];
		evicts_nxt = (evicts_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX
			: evicts_sum[TOTAL_WIDTH-1:0];
		// the result shows the low 32 bits of each total
		hits_ext   = 64'(hits_nxt);
		misses_ext = 64'(misses_nxt);
		evicts_ext = 64'(evicts_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			misses_q <= '0;
			evicts_q <= '0;
		end else if (s1_fire) begin
			hits_q   <= hits_nxt;
			misses_q <= misses_nxt;
			evicts_q <= evicts_nxt;
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_hit_q    <= lk_stat.hit;
			res_miss_q   <= !lk_stat.hit;
			res_evict_q  <= lk_stat.evicted;
			res_twice_q  <= twice_s1;
			res_hits_q   <= hits_ext[OUT_TOTAL_W-1:0];
			res_misses_q <= misses_ext[OUT_TOTAL_W-1:0];
			res_evicts_q <= evicts_ext[OUT_TOTAL_W-1:0];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0, res_evicts_q, res_misses_q, res_hits_q,
		res_twice_q, res_evict_q, res_miss_q, res_hit_q};

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	// a set read never meets a write back or a clearing write
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("set memory read and write in the same cycle");

	// no access reaches the compare stage while the memory is being cleared
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy_q |-> !valid_s1)
		else $error("access in flight during clearing pass");

	// totals only move when an access completes
	a_totals_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_fire |=> $stable(hits_q) && $stable(misses_q) && $stable(evicts_q))
		else $error("totals changed without a completed access");

	// totals never go down
	a_totals_grow: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> (hits_q >= $past(hits_q)) && (misses_q >= $past(misses_q))
			&& (evicts_q >= $past(evicts_q)))
		else $error("total decreased");

	// an eviction only comes with a miss, and exactly one of hit and miss is set
	a_evict_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (!res_evict_q || res_miss_q) && (res_hit_q != res_miss_q))
		else $error("inconsistent result flags");

endmodule

/* rtl/salc_lookup.sv */
// ----------------------------------------------------------------------------
// salc_lookup
// tag compare, victim choice and lru update for one set row
// ----------------------------------------------------------------------------
module salc_lookup #(
	parameter int WAY_COUNT = salc_pkg::WAY_COUNT_DEF,
	parameter int REC_W     = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1
) (
	input  logic [salc_pkg::WAYS_W-1:0] ways_used,
	input  logic [salc_pkg::ADDR_W-1:0] tag,
	input  logic                        row_valid [WAY_COUNT],
	input  logic [salc_pkg::ADDR_W-1:0] row_tag   [WAY_COUNT],
	input  logic [REC_W-1:0]            row_rec   [WAY_COUNT],
	output logic                        new_valid [WAY_COUNT],
	output logic [salc_pkg::ADDR_W-1:0] new_tag   [WAY_COUNT],
	output logic [REC_W-1:0]            new_rec   [WAY_COUNT],
	output salc_pkg::lookup_stat_t      stat
);
	import salc_pkg::*;

	localparam logic [REC_W-1:0] AGE_TOP = REC_W'(WAY_COUNT - 1);

	logic [WAY_COUNT-1:0] in_use;
	logic [WAY_COUNT-1:0] match;
	logic [WAY_COUNT-1:0] hit_oh;
	logic [WAY_COUNT-1:0] inv_oh;
	logic [WAY_COUNT-1:0] lru_oh;
	logic [WAY_COUNT-1:0] sel;
	logic [WAY_COUNT-1:0] bump;
	logic                 hit;
	logic                 has_inv;
	logic                 t_valid;
	logic [REC_W-1:0]     t_rec;
	logic                 seen_match;
	logic                 seen_inv;

	// way 0 is always in use, the rest up to the configured count
	always_comb begin
		for (int w = 0; w < WAY_COUNT; w++) begin
			in_use[w] = (w == 0) || ({1'b0, ways_used} > (WAYS_W + 1)'(w));
			match[w]  = in_use[w] && row_valid[w] && (row_tag[w] == tag);
		end
	end

	// lowest matching way and lowest free way
	always_comb begin
		seen_match = 1'b0;
		seen_inv   = 1'b0;
		for (int w = 0; w < WAY_COUNT; w++) begin
			hit_oh[w]  = match[w] && !seen_match;
			inv_oh[w]  = in_use[w] && !row_valid[w] && !seen_inv;
			seen_match = seen_match || match[w];
			seen_inv   = seen_inv || (in_use[w] && !row_valid[w]);
		end
		hit     = seen_match;
		has_inv = seen_inv;
	end

	// oldest way, lowest index on ties, as a compare matrix
	always_comb begin
		for (int w = 0; w < WAY_COUNT; w++) begin
			lru_oh[w] = in_use[w];
			for (int v = 0; v < WAY_COUNT; v++) begin
				if (v < w && in_use[v] && !(row_rec[w] > row_rec[v])) begin
					lru_oh[w] = 1'b0;
				end
				if (v > w && in_use[v] && (row_rec[v] > row_rec[w])) begin
					lru_oh[w] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		priority if (hit) begin
			sel = hit_oh;
		end else if (has_inv) begin
			sel = inv_oh;
		end else begin
			sel = lru_oh;
		end
	end

	// age limit comes from the chosen way if it held a line
	always_comb begin
		t_valid = 1'b0;
		t_rec   = '0;
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (sel[w]) begin
				t_valid = row_valid[w];
				t_rec   = row_rec[w];
			end
		end
	end

	always_comb begin
		for (int w = 0; w < WAY_COUNT; w++) begin
			bump[w] = !sel[w] && in_use[w] && row_valid[w] &&
				(!t_valid || (row_rec[w] < t_rec)) && (row_rec[w] < AGE_TOP);
			new_valid[w] = row_valid[w] || sel[w];
			new_tag[w]   = (sel[w] && !hit) ? tag : row_tag[w];
			if (sel[w]) begin
				new_rec[w] = '0;
			end else if (bump[w]) begin
				new_rec[w] = row_rec[w] + REC_W'(1);
			end else begin
				new_rec[w] = row_rec[w];
			end
		end
		stat.hit     = hit;
		stat.evicted = !hit && !has_inv;
	end

endmodule
